FILE: rtl/core/qat_pkg.sv
// Shared types, character codes and result codes of the argument tokenizer.
`timescale 1ns / 1ps

package qat_pkg;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NUL    = 8'h00;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_START   = 2'd0,
      KIND_CHAR    = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_UNCLOSED = 2'd1,
      STATUS_TOO_MANY = 2'd2
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] arg_index;
      logic [7:0] arg_char;
      status_type status;
      logic [2:0] arg_count;
   } result_type;

   // results caused by one character; second is used only when two is set
   typedef struct packed {
      result_type first;
      result_type second;
      logic       two;
   } record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic result_type make_result(kind_type k, logic [1:0] idx, logic [7:0] c,
                                              status_type s, logic [2:0] n);
      result_type r;
      r.kind      = k;
      r.arg_index = idx;
      r.arg_char  = c;
      r.status    = s;
      r.arg_count = n;
      return r;
   endfunction

endpackage

FILE: rtl/core/qat_front.sv
// Front end: accepts characters, tracks quoting state and builds result records.
`timescale 1ns / 1ps

module qat_front import qat_pkg::*; #(
   parameter int MAX_ARGS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_line_char,
   input  logic             req_line_end,
   input  queue_status_type q_status,
   output logic             push,
   output record_type       push_rec
);

   localparam int CNT_W = $clog2(MAX_ARGS + 1);
   localparam int EXT_W = CNT_W + 3;

   logic             in_arg_ff, in_arg_in;
   logic             in_quote_ff, in_quote_in;
   logic             pend_ff, pend_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             accept;
   logic             is_end;
   logic             at_limit;
   logic [EXT_W-1:0] cnt_ext;
   logic [EXT_W-1:0] cnt_m1_ext;
   logic [1:0]       cur_idx;
   logic [1:0]       new_idx;
   logic [2:0]       cnt_out;
   logic [1:0]       n_res;
   result_type       r0, r1;
   status_type       end_status;

   assign req_ready  = !q_status.full;
   assign accept     = req_valid && req_ready;
   assign is_end     = req_line_end || (req_line_char == CH_NUL);
   assign at_limit   = count_ff >= CNT_W'(MAX_ARGS);
   assign cnt_ext    = EXT_W'(count_ff);
   assign cnt_m1_ext = cnt_ext - EXT_W'(1);
   assign cur_idx    = (count_ff == '0) ? 2'd0 : cnt_m1_ext[1:0];
   assign new_idx    = cnt_ext[1:0];
   assign cnt_out    = cnt_ext[2:0];
   assign end_status = ovf_ff ? STATUS_TOO_MANY : (in_quote_ff ? STATUS_UNCLOSED : STATUS_OK);

   always_comb begin
      in_arg_in   = in_arg_ff;
      in_quote_in = in_quote_ff;
      pend_in     = pend_ff;
      ovf_in      = ovf_ff;
      count_in    = count_ff;
      n_res       = 2'd0;
      r0          = make_result(KIND_START, 2'd0, CH_NUL, STATUS_OK, 3'd0);
      r1          = r0;
      priority if (is_end) begin
         if (pend_ff) begin
            r0    = make_result(KIND_CHAR, cur_idx, CH_BSLASH, STATUS_OK, 3'd0);
            r1    = make_result(KIND_SUMMARY, 2'd0, CH_NUL, end_status, cnt_out);
            n_res = 2'd2;
         end else begin
            r0    = make_result(KIND_SUMMARY, 2'd0, CH_NUL, end_status, cnt_out);
            n_res = 2'd1;
         end
         in_arg_in   = 1'b0;
         in_quote_in = 1'b0;
         pend_in     = 1'b0;
         ovf_in      = 1'b0;
         count_in    = '0;
      end else if (ovf_ff) begin
         n_res = 2'd0;
      end else if (req_line_char == CH_QUOTE) begin
         priority if (pend_ff) begin
            pend_in = 1'b0;
            r0      = make_result(KIND_CHAR, cur_idx, CH_QUOTE, STATUS_OK, 3'd0);
            n_res   = 2'd1;
         end else if (in_arg_ff && !in_quote_ff) begin
            r0    = make_result(KIND_CHAR, cur_idx, CH_QUOTE, STATUS_OK, 3'd0);
            n_res = 2'd1;
         end else if (in_arg_ff) begin
            in_arg_in   = 1'b0;
            in_quote_in = 1'b0;
         end else if (at_limit) begin
            ovf_in = 1'b1;
         end else begin
            count_in    = count_ff + CNT_W'(1);
            in_arg_in   = 1'b1;
            in_quote_in = 1'b1;
            r0          = make_result(KIND_START, new_idx, CH_NUL, STATUS_OK, 3'd0);
            n_res       = 2'd1;
         end
      end else if (req_line_char == CH_SPACE) begin
         priority if (pend_ff) begin
            pend_in = 1'b0;
            r0      = make_result(KIND_CHAR, cur_idx, CH_SPACE, STATUS_OK, 3'd0);
            n_res   = 2'd1;
         end else if (in_arg_ff && !in_quote_ff) begin
            in_arg_in = 1'b0;
         end else if (in_quote_ff) begin
            r0    = make_result(KIND_CHAR, cur_idx, CH_SPACE, STATUS_OK, 3'd0);
            n_res = 2'd1;
         end else begin
            n_res = 2'd0;
         end
      end else begin
         // a held backslash implies an open argument
         priority if (pend_ff) begin
            r0 = make_result(KIND_CHAR, cur_idx, CH_BSLASH, STATUS_OK, 3'd0);
            if (req_line_char == CH_BSLASH) begin
               n_res = 2'd1;
            end else begin
               pend_in = 1'b0;
               r1      = make_result(KIND_CHAR, cur_idx, req_line_char, STATUS_OK, 3'd0);
               n_res   = 2'd2;
            end
         end else if (!in_arg_ff && at_limit) begin
            ovf_in = 1'b1;
         end else if (!in_arg_ff) begin
            count_in  = count_ff + CNT_W'(1);
            in_arg_in = 1'b1;
            r0        = make_result(KIND_START, new_idx, CH_NUL, STATUS_OK, 3'd0);
            if (req_line_char == CH_BSLASH) begin
               pend_in = 1'b1;
               n_res   = 2'd1;
            end else begin
               r1    = make_result(KIND_CHAR, new_idx, req_line_char, STATUS_OK, 3'd0);
               n_res = 2'd2;
            end
         end else if (req_line_char == CH_BSLASH) begin
            pend_in = 1'b1;
         end else begin
            r0    = make_result(KIND_CHAR, cur_idx, req_line_char, STATUS_OK, 3'd0);
            n_res = 2'd1;
         end
      end
   end

   assign push            = accept && (n_res != 2'd0);
   assign push_rec.first  = r0;
   assign push_rec.second = r1;
   assign push_rec.two    = n_res == 2'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_arg_ff   <= 1'b0;
         in_quote_ff <= 1'b0;
         pend_ff     <= 1'b0;
         ovf_ff      <= 1'b0;
         count_ff    <= '0;
      end else if (accept) begin
         in_arg_ff   <= in_arg_in;
         in_quote_ff <= in_quote_in;
         pend_ff     <= pend_in;
         ovf_ff      <= ovf_in;
         count_ff    <= count_in;
      end
   end

endmodule

FILE: rtl/core/qat_queue.sv
// Record queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module qat_queue import qat_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  record_type       push_rec,
   input  logic             pop,
   output record_type       head_rec,
   output queue_status_type q_status
);

   record_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;

   assign q_status.full  = fill_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_status.empty = fill_ff == '0;
   assign head_rec       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: rtl/core/qat_back.sv
// Output sequencer: sends the one or two results of each queued record in order.
`timescale 1ns / 1ps

module qat_back import qat_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  record_type       head_rec,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [1:0]       rsp_arg_index,
   output logic [7:0]       rsp_arg_char,
   output logic [1:0]       rsp_status,
   output logic [2:0]       rsp_arg_count,
   output logic             rsp_last
);

   logic       sub_ff, sub_in;
   logic       xfer;
   result_type cur;

   assign rsp_valid     = !q_status.empty;
   assign cur           = sub_ff ? head_rec.second : head_rec.first;
   assign rsp_last      = sub_ff || !head_rec.two;
   assign xfer          = rsp_valid && rsp_ready;
   assign pop           = xfer && rsp_last;
   assign rsp_kind      = cur.kind;
   assign rsp_arg_index = cur.arg_index;
   assign rsp_arg_char  = cur.arg_char;
   assign rsp_status    = cur.status;
   assign rsp_arg_count = cur.arg_count;

   always_comb begin
      sub_in = sub_ff;
      if (xfer) begin
         sub_in = !rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

FILE: rtl/core/quoted_argument_tokenizer.sv
// Top level of the quoted argument tokenizer.
`timescale 1ns / 1ps

// Takes one line character per cycle and splits the line into at most MAX_ARGS
// arguments, sending argument-start, argument-character and end-of-line summary
// results. The front end classifies a character and updates the quoting state in
// the cycle it is taken; a character causes zero, one or two results, which go as
// one record into a four-entry queue. The output sequencer sends the results of a
// record one at a time, popping the record after its last one has gone out, and
// input is only stalled when the queue is full.

module quoted_argument_tokenizer import qat_pkg::*; #(
   parameter int MAX_ARGS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_line_char,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [1:0] rsp_arg_index,
   output logic [7:0] rsp_arg_char,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_arg_count,
   output logic       rsp_last
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   record_type       push_rec;
   record_type       head_rec;

   qat_front #(
      .MAX_ARGS(MAX_ARGS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_line_char (req_line_char),
      .req_line_end  (req_line_end),
      .q_status      (q_status),
      .push          (push),
      .push_rec      (push_rec)
   );

   qat_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_status (q_status)
   );

   qat_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_rec      (head_rec),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_arg_index (rsp_arg_index),
      .rsp_arg_char  (rsp_arg_char),
      .rsp_status    (rsp_status),
      .rsp_arg_count (rsp_arg_count),
      .rsp_last      (rsp_last)
   );

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SUMMARY) |-> rsp_last)
      else $error("summary not marked last");

   a_plain_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_SUMMARY) |-> (rsp_status == STATUS_OK) &&
      (rsp_arg_count == 3'd0))
      else $error("status or count set on a non-summary result");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("second result of a record missing");

endmodule
